>>> sv/ukf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukf_pkg
// Types and codes shared by the unique key fifo and its entry store.
// ----------------------------------------------------------------------------
package ukf_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_SRCH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_DUP      = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_EMPTY    = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_key;
    logic [31:0] found_payload;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] payload;
  } entry_t;

endpackage

>>> sv/unique_key_fifo_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_fifo_with_search
// Bounded fifo of keyed words with duplicate check on enqueue and key search.
// ----------------------------------------------------------------------------
// enqueue and search scan the ring from the head, one stored key per cycle
// through the single memory read port, and end on the first hit or when
// every waiting entry has been compared; dequeue and the unused kind pass
// through the pop state only; busy drops with the strobe so the
// next word can be taken in the strobe cycle; the receiver cannot stall
// reset clears head, tail, count and control; the memory is not cleared
module unique_key_fifo_with_search import ukf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  state_e        state_q, state_d;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;
  logic          done_q, done_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic          cmp_vld_q, cmp_vld_d;

  logic          we;
  logic [AW-1:0] raddr;
  entry_t        wdata;
  entry_t        rdata;
  logic          hit;
  logic [31:0]   occ_ext;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  ukf_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign wdata.key     = req_q.key;
  assign wdata.payload = req_q.payload;
  assign hit           = cmp_vld_q && (rdata.key == req_q.key);
  assign occ_ext       = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      left_q    <= '0;
      pos_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      left_q    <= left_d;
      pos_q     <= pos_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    left_d    = left_q;
    pos_d     = pos_q;
    cmp_vld_d = 1'b0;
    we        = 1'b0;
    raddr     = head_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          pos_d  = head_q;
          left_d = count_q;
          if (req_i.kind inside {KIND_ENQ, KIND_SRCH}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_POP;
          end
        end
      end
      S_SCAN: begin
        raddr = pos_q;
        if (hit || (!cmp_vld_q && (left_q == '0))) begin
          state_d             = S_IDLE;
          done_d              = 1'b1;
          rsp_d.status        = STATUS_OK;
          rsp_d.found_key     = '0;
          rsp_d.found_payload = '0;
          if (req_q.kind == KIND_ENQ) begin
            if (hit) begin
              rsp_d.status = STATUS_DUP;
            end else if (count_q == FullCnt) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              we      = 1'b1;
              tail_d  = ring_next(tail_q);
              count_d = count_q + CW'(1);
            end
          end else begin
            if (count_q == '0) begin
              rsp_d.status = STATUS_EMPTY;
            end else if (hit) begin
              rsp_d.found_key     = rdata.key;
              rsp_d.found_payload = rdata.payload;
            end else begin
              rsp_d.status = STATUS_NOTFOUND;
            end
          end
        end else if (left_q != '0) begin
          pos_d     = ring_next(pos_q);
          left_d    = left_q - CW'(1);
          cmp_vld_d = 1'b1;
        end
      end
      S_POP: begin
        state_d             = S_IDLE;
        done_d              = 1'b1;
        rsp_d.status        = STATUS_OK;
        rsp_d.found_key     = '0;
        rsp_d.found_payload = '0;
        if (req_q.kind == KIND_DEQ) begin
          if (count_q == '0) begin
            rsp_d.status = STATUS_EMPTY;
          end else begin
            rsp_d.found_key     = rdata.key;
            rsp_d.found_payload = rdata.payload;
            head_d              = ring_next(head_q);
            count_d             = count_q - CW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      rsp_d.occupancy = occ_ext[4:0];
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> sv/ukf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukf_store
// Entry ring memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ukf_store import ukf_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
